/* src/sbmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmt_pkg: shared types and constants of the sparse boolean matrix table
// Item layouts, operation codes, sequencer states and table sizes.
// ----------------------------------------------------------------------------
package sbmt_pkg;

    // table size and derived widths
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = 8;
    localparam int KEY_W    = 2 * IDX_W;

    // operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TEST   = 2'd1,
        OP_GETROW = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_INS_RD,
        ST_INS_WR,
        ST_TEST_CMP,
        ST_ROW_RD,
        ST_ROW_EMIT,
        ST_RESP
    } state_t;

    // input item
    typedef struct packed {
        logic [1:0]       operation;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } in_item_t;

    // result item
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] col_out;
        logic             col_valid;
        logic             status;
        logic             last;
    } out_item_t;

endpackage

/* src/sbmt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmt_ram: generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module sbmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/sparse_bool_matrix_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_bool_matrix_table: sorted (row, col) table with binary search
// Insert, test, get row and clear on a sorted list of set matrix cells.
// ----------------------------------------------------------------------------
// The table holds up to sbmt_pkg::CAPACITY keys {row, col} in one RAM, sorted
// ascending, and one sequencer with a single key comparator does all the work;
// the block takes one item at a time and s_ready is high only between items.
// A search step is a RAM read at the midpoint followed by a compare. Test then
// reads the entry at the found position and checks it for equality. Insert
// moves every key above the insert position up one place, a read then a
// write per key. Get row runs two searches and then reads and emits each
// column in turn. Clear and an insert into a full table go straight to the
// response. A finished result sits in an output register, so the next
// item can enter while it waits.
// ----------------------------------------------------------------------------
module sparse_bool_matrix_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sbmt_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output sbmt_pkg::out_item_t m_item
);

    // control registers
    sbmt_pkg::state_t             state_reg, state_next;
    logic [sbmt_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                         m_valid_reg, m_valid_next;

    // working registers
    logic [1:0]                   op_reg, op_next;
    logic [sbmt_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [sbmt_pkg::IDX_W-1:0]   row_reg, row_next;
    logic                         upper_reg, upper_next;
    logic                         phase_reg, phase_next;
    logic [sbmt_pkg::CNT_W-1:0]   lo_reg, lo_next;
    logic [sbmt_pkg::CNT_W-1:0]   hi_reg, hi_next;
    logic [sbmt_pkg::CNT_W-1:0]   first_reg, first_next;
    logic [sbmt_pkg::CNT_W-1:0]   idx_reg, idx_next;
    sbmt_pkg::out_item_t          res_reg, res_next;
    sbmt_pkg::out_item_t          m_item_reg, m_item_next;

    // ram port signals
    logic                         ram_we;
    logic [sbmt_pkg::ADDR_W-1:0]  ram_waddr;
    logic [sbmt_pkg::KEY_W-1:0]   ram_wdata;
    logic                         ram_re;
    logic [sbmt_pkg::ADDR_W-1:0]  ram_raddr;
    logic [sbmt_pkg::KEY_W-1:0]   ram_rdata;

    // search helpers
    logic [sbmt_pkg::CNT_W:0]     mid_sum;
    logic [sbmt_pkg::CNT_W-1:0]   mid;
    logic                         key_below;
    logic                         out_free;
    logic                         accept;
    logic [sbmt_pkg::CNT_W-1:0]   idx_inc;

    sbmt_ram #(
        .WIDTH (sbmt_pkg::KEY_W),
        .DEPTH (sbmt_pkg::CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // midpoint and the shared key comparator
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[sbmt_pkg::CNT_W:1];
    assign key_below = upper_reg ? (ram_rdata <= key_reg) : (ram_rdata < key_reg);
    assign idx_inc   = idx_reg + sbmt_pkg::CNT_W'(1);

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == sbmt_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // sequencer: next state and datapath control
    always_comb begin
        logic out_load;
        out_load     = 1'b0;
        state_next   = state_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        row_next     = row_reg;
        upper_next   = upper_reg;
        phase_next   = phase_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        first_next   = first_reg;
        idx_next     = idx_reg;
        res_next     = res_reg;
        m_item_next  = m_item_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg[sbmt_pkg::ADDR_W-1:0];
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = mid[sbmt_pkg::ADDR_W-1:0];

        unique case (state_reg)
            sbmt_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next    = s_item.operation;
                    row_next   = s_item.row;
                    key_next   = {s_item.row, s_item.col};
                    lo_next    = '0;
                    hi_next    = count_reg;
                    phase_next = 1'b0;
                    res_next   = '0;
                    res_next.last = 1'b1;
                    unique case (s_item.operation)
                        sbmt_pkg::OP_INSERT: begin
                            if (count_reg >= sbmt_pkg::CNT_W'(sbmt_pkg::CAPACITY)) begin
                                res_next.status = 1'b1;
                                state_next      = sbmt_pkg::ST_RESP;
                            end else begin
                                upper_next = 1'b1;
                                state_next = sbmt_pkg::ST_SEARCH;
                            end
                        end
                        sbmt_pkg::OP_TEST: begin
                            upper_next = 1'b0;
                            state_next = sbmt_pkg::ST_SEARCH;
                        end
                        sbmt_pkg::OP_GETROW: begin
                            key_next   = {s_item.row, {sbmt_pkg::IDX_W{1'b0}}};
                            upper_next = 1'b0;
                            state_next = sbmt_pkg::ST_SEARCH;
                        end
                        default: begin
                            count_next = '0;
                            state_next = sbmt_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            // one search step: read the midpoint, or finish
            sbmt_pkg::ST_SEARCH: begin
                if (lo_reg < hi_reg) begin
                    ram_re     = 1'b1;
                    state_next = sbmt_pkg::ST_COMPARE;
                end else begin
                    unique case (op_reg)
                        sbmt_pkg::OP_INSERT: begin
                            idx_next   = count_reg;
                            state_next = sbmt_pkg::ST_INS_RD;
                        end
                        sbmt_pkg::OP_TEST: begin
                            if (lo_reg < count_reg) begin
                                ram_re     = 1'b1;
                                ram_raddr  = lo_reg[sbmt_pkg::ADDR_W-1:0];
                                state_next = sbmt_pkg::ST_TEST_CMP;
                            end else begin
                                state_next = sbmt_pkg::ST_RESP;
                            end
                        end
                        default: begin
                            if (!phase_reg) begin
                                // lower bound found, now search the row's end
                                first_next = lo_reg;
                                key_next   = {row_reg, {sbmt_pkg::IDX_W{1'b1}}};
                                upper_next = 1'b1;
                                phase_next = 1'b1;
                                lo_next    = '0;
                                hi_next    = count_reg;
                            end else if (first_reg >= lo_reg) begin
                                state_next = sbmt_pkg::ST_RESP;
                            end else begin
                                idx_next   = first_reg;
                                state_next = sbmt_pkg::ST_ROW_RD;
                            end
                        end
                    endcase
                end
            end

            sbmt_pkg::ST_COMPARE: begin
                if (key_below) begin
                    lo_next = mid + sbmt_pkg::CNT_W'(1);
                end else begin
                    hi_next = mid;
                end
                state_next = sbmt_pkg::ST_SEARCH;
            end

            // move keys up one place until the insert position is free
            sbmt_pkg::ST_INS_RD: begin
                if (idx_reg > lo_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = sbmt_pkg::ADDR_W'(idx_reg - sbmt_pkg::CNT_W'(1));
                    state_next = sbmt_pkg::ST_INS_WR;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = lo_reg[sbmt_pkg::ADDR_W-1:0];
                    ram_wdata  = key_reg;
                    count_next = count_reg + sbmt_pkg::CNT_W'(1);
                    state_next = sbmt_pkg::ST_RESP;
                end
            end

            sbmt_pkg::ST_INS_WR: begin
                ram_we     = 1'b1;
                idx_next   = idx_reg - sbmt_pkg::CNT_W'(1);
                state_next = sbmt_pkg::ST_INS_RD;
            end

            sbmt_pkg::ST_TEST_CMP: begin
                res_next.hit = (ram_rdata == key_reg);
                state_next   = sbmt_pkg::ST_RESP;
            end

            // row scan: read one entry, then emit its column
            sbmt_pkg::ST_ROW_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg[sbmt_pkg::ADDR_W-1:0];
                state_next = sbmt_pkg::ST_ROW_EMIT;
            end

            sbmt_pkg::ST_ROW_EMIT: begin
                if (out_free) begin
                    out_load              = 1'b1;
                    m_item_next           = '0;
                    m_item_next.col_out   = ram_rdata[sbmt_pkg::IDX_W-1:0];
                    m_item_next.col_valid = 1'b1;
                    m_item_next.last      = (idx_inc == lo_reg);
                    idx_next              = idx_inc;
                    state_next            = (idx_inc == lo_reg) ? sbmt_pkg::ST_IDLE
                                                                : sbmt_pkg::ST_ROW_RD;
                end
            end

            sbmt_pkg::ST_RESP: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    m_item_next = res_reg;
                    state_next  = sbmt_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = sbmt_pkg::ST_IDLE;
            end
        endcase

        // output register handshake
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sbmt_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        row_reg    <= row_next;
        upper_reg  <= upper_next;
        phase_reg  <= phase_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        first_reg  <= first_next;
        idx_reg    <= idx_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    // fill count never passes the capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sbmt_pkg::CNT_W'(sbmt_pkg::CAPACITY))
        else $error("fill count above capacity");

    // search window stays ordered
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sbmt_pkg::ST_SEARCH) |-> (lo_reg <= hi_reg))
        else $error("search window inverted");

    // a clear empties the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.operation == sbmt_pkg::OP_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries");

    // a refused insert leaves the fill count alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.operation == sbmt_pkg::OP_INSERT &&
         count_reg == sbmt_pkg::CNT_W'(sbmt_pkg::CAPACITY)) |=> $stable(count_reg))
        else $error("full insert changed the table");

    // a result never carries both a column and a refusal
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_item_reg.status && m_item_reg.col_valid))
        else $error("column and refusal on one item");

endmodule

/* dv/tb_sparse_bool_matrix_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_bool_matrix_table: self-checking bench for the sorted pair table
// Drives insert, test, get row and clear items through the valid/ready input
// channel with random gaps, stalls the result channel at random, and checks
// every result against a sorted key list kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_sparse_bool_matrix_table;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 64;

    // expected-result store and table predictor
    class sbmt_scoreboard;
        logic [sbmt_pkg::KEY_W-1:0] sorted_keys[$];
        sbmt_pkg::out_item_t        pending_results[$];
        int                         errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function int key_count();
            return sorted_keys.size();
        endfunction

        function logic [sbmt_pkg::KEY_W-1:0] key_at(int idx);
            return sorted_keys[idx];
        endfunction

        // first index not below key, or first index above key when strict
        function int bound_index(logic [sbmt_pkg::KEY_W-1:0] key, bit strict);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = sorted_keys.size();
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (sorted_keys[mid] < key || (strict && sorted_keys[mid] == key)) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            return lo;
        endfunction

        function void push_result(logic hit, logic [sbmt_pkg::IDX_W-1:0] col,
                                  logic col_valid, logic status, logic last);
            sbmt_pkg::out_item_t r;
            r.hit       = hit;
            r.col_out   = col;
            r.col_valid = col_valid;
            r.status    = status;
            r.last      = last;
            pending_results.insert(pending_results.size(), r);
        endfunction

        // update the table and queue what the accepted item must produce
        function void note_item(sbmt_pkg::in_item_t it);
            logic [sbmt_pkg::KEY_W-1:0] key;
            int                         pos;
            int                         first;
            int                         stop;
            key = {it.row, it.col};
            case (sbmt_pkg::op_t'(it.operation))
                sbmt_pkg::OP_INSERT: begin
                    if (sorted_keys.size() >= sbmt_pkg::CAPACITY) begin
                        push_result(1'b0, '0, 1'b0, 1'b1, 1'b1);
                    end else begin
                        // duplicates go after equal keys
                        pos = bound_index(key, 1'b1);
                        sorted_keys.insert(pos, key);
                        push_result(1'b0, '0, 1'b0, 1'b0, 1'b1);
                    end
                end
                sbmt_pkg::OP_TEST: begin
                    pos = bound_index(key, 1'b0);
                    push_result((pos < sorted_keys.size()) && (sorted_keys[pos] == key),
                                '0, 1'b0, 1'b0, 1'b1);
                end
                sbmt_pkg::OP_GETROW: begin
                    first = bound_index({it.row, 8'h00}, 1'b0);
                    stop  = bound_index({it.row, 8'hFF}, 1'b1);
                    if (first >= stop) begin
                        push_result(1'b0, '0, 1'b0, 1'b0, 1'b1);
                    end else begin
                        for (int i = first; i < stop; i++) begin
                            push_result(1'b0, sorted_keys[i][sbmt_pkg::IDX_W-1:0], 1'b1,
                                        1'b0, i == stop - 1);
                        end
                    end
                end
                default: begin
                    sorted_keys.delete();
                    push_result(1'b0, '0, 1'b0, 1'b0, 1'b1);
                end
            endcase
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(sbmt_pkg::out_item_t got);
            sbmt_pkg::out_item_t want;
            bit                  bad;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h, nothing expected", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            bad  = 1'b0;
            if (got.hit !== want.hit) begin
                $display("%0t: hit expected %0d, actual %0d", $time, want.hit, got.hit);
                bad = 1'b1;
            end
            if (got.col_out !== want.col_out) begin
                $display("%0t: col_out expected %0d, actual %0d", $time,
                         want.col_out, got.col_out);
                bad = 1'b1;
            end
            if (got.col_valid !== want.col_valid) begin
                $display("%0t: col_valid expected %0d, actual %0d", $time,
                         want.col_valid, got.col_valid);
                bad = 1'b1;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d, actual %0d", $time,
                         want.status, got.status);
                bad = 1'b1;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d, actual %0d", $time, want.last, got.last);
                bad = 1'b1;
            end
            if (bad) begin
                errors++;
            end
        endfunction
    endclass

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    sbmt_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    sbmt_pkg::out_item_t m_item;

    sbmt_scoreboard sb = new();

    bit         no_idle = 1'b0;
    int         stall_left = 0;
    int         idle_cycles = 0;
    logic [7:0] row_pool[4];

    sparse_bool_matrix_table uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // clock, 4 ns period
    always #2 aclk = ~aclk;

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        if (no_idle) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] v;
        v = $urandom;
        return v[7:0];
    endfunction

    function automatic sbmt_pkg::in_item_t make_item(sbmt_pkg::op_t op, logic [7:0] r,
                                                     logic [7:0] c);
        sbmt_pkg::in_item_t it;
        it.operation = op;
        it.row       = r;
        it.col       = c;
        return it;
    endfunction

    // random item aimed at a few busy rows, with stored keys reused for hits
    function automatic sbmt_pkg::in_item_t mixed_item();
        logic [31:0]                raw;
        int                         roll;
        sbmt_pkg::op_t              op;
        logic [7:0]                 r;
        logic [7:0]                 c;
        logic [sbmt_pkg::KEY_W-1:0] key;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            raw = $urandom;
            return raw[$bits(sbmt_pkg::in_item_t)-1:0];
        end
        roll = $urandom_range(0, 99);
        if (roll < 45) op = sbmt_pkg::OP_INSERT;
        else if (roll < 75) op = sbmt_pkg::OP_TEST;
        else if (roll < 95) op = sbmt_pkg::OP_GETROW;
        else op = sbmt_pkg::OP_CLEAR;
        r = ($urandom_range(0, 3) != 0) ? row_pool[$urandom_range(0, 3)] : rand_byte();
        c = rand_byte();
        if (op != sbmt_pkg::OP_INSERT && sb.key_count() > 0 && $urandom_range(0, 1) == 1) begin
            key = sb.key_at($urandom_range(0, sb.key_count() - 1));
            r   = key[15:8];
            c   = key[7:0];
        end
        return make_item(op, r, c);
    endfunction

    // present one item and hold it until accepted
    task automatic send_item(input sbmt_pkg::in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
    endtask

    // stop sending until every expected result has come back
    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // result channel back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) begin
                stall_left = pick_gap();
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_item);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // stimulus
    initial begin
        logic [7:0] base_row;
        logic [sbmt_pkg::KEY_W-1:0] key;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, corner pairs, duplicates, hits and misses
        send_item(make_item(sbmt_pkg::OP_TEST,   8'd0,   8'd0));
        send_item(make_item(sbmt_pkg::OP_GETROW, 8'd0,   rand_byte()));
        send_item(make_item(sbmt_pkg::OP_TEST,   8'd255, 8'd255));
        send_item(make_item(sbmt_pkg::OP_INSERT, 8'd0,   8'd0));
        send_item(make_item(sbmt_pkg::OP_INSERT, 8'd255, 8'd255));
        send_item(make_item(sbmt_pkg::OP_INSERT, 8'd0,   8'd255));
        send_item(make_item(sbmt_pkg::OP_INSERT, 8'd255, 8'd0));
        send_item(make_item(sbmt_pkg::OP_INSERT, 8'd0,   8'd0));
        send_item(make_item(sbmt_pkg::OP_INSERT, 8'd128, 8'd127));
        send_item(make_item(sbmt_pkg::OP_TEST,   8'd0,   8'd0));
        send_item(make_item(sbmt_pkg::OP_TEST,   8'd255, 8'd255));
        send_item(make_item(sbmt_pkg::OP_TEST,   8'd0,   8'd255));
        send_item(make_item(sbmt_pkg::OP_TEST,   8'd255, 8'd0));
        send_item(make_item(sbmt_pkg::OP_TEST,   8'd0,   8'd1));
        send_item(make_item(sbmt_pkg::OP_TEST,   8'd128, 8'd128));
        send_item(make_item(sbmt_pkg::OP_TEST,   8'd127, 8'd255));
        send_item(make_item(sbmt_pkg::OP_GETROW, 8'd0,   rand_byte()));
        send_item(make_item(sbmt_pkg::OP_GETROW, 8'd255, rand_byte()));
        send_item(make_item(sbmt_pkg::OP_GETROW, 8'd1,   rand_byte()));
        send_item(make_item(sbmt_pkg::OP_GETROW, 8'd128, rand_byte()));
        send_item(make_item(sbmt_pkg::OP_CLEAR,  rand_byte(), rand_byte()));
        send_item(make_item(sbmt_pkg::OP_TEST,   8'd0,   8'd0));
        send_item(make_item(sbmt_pkg::OP_GETROW, 8'd0,   rand_byte()));
        wait_drain();

        // fill one row to capacity, then overflow and a full-row scan
        base_row = rand_byte();
        send_item(make_item(sbmt_pkg::OP_CLEAR, rand_byte(), rand_byte()));
        for (int i = 0; i < sbmt_pkg::CAPACITY; i++) begin
            send_item(make_item(sbmt_pkg::OP_INSERT, base_row, rand_byte()));
        end
        wait_drain();
        send_item(make_item(sbmt_pkg::OP_INSERT, rand_byte(), rand_byte()));
        send_item(make_item(sbmt_pkg::OP_INSERT, base_row, rand_byte()));
        send_item(make_item(sbmt_pkg::OP_GETROW, base_row, rand_byte()));
        for (int i = 0; i < 4; i++) begin
            key = sb.key_at($urandom_range(0, sbmt_pkg::CAPACITY - 1));
            send_item(make_item(sbmt_pkg::OP_TEST, key[15:8],
                                (i < 2) ? key[7:0] : rand_byte()));
        end
        send_item(make_item(sbmt_pkg::OP_GETROW, base_row + 8'd1, rand_byte()));
        wait_drain();

        // mixed traffic on a few busy rows, first stretch without idling
        send_item(make_item(sbmt_pkg::OP_CLEAR, rand_byte(), rand_byte()));
        foreach (row_pool[i]) begin
            row_pool[i] = rand_byte();
        end
        row_pool[0] = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'd255;
        for (int i = 0; i < 90; i++) begin
            no_idle = (i < 25);
            send_item(mixed_item());
        end
        no_idle = 1'b0;

        // let everything come back, then a short settle
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never came", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
src/sbmt_pkg.sv
src/sbmt_ram.sv
src/sparse_bool_matrix_table.sv
dv/tb_sparse_bool_matrix_table.sv
